// ----- hw/rtl/scint_pkg.sv -----
// ----------------------------------------------------------------------------
// scint_pkg
// Shared widths, types and constants for the segment / circle intersection
// pipeline.
// ----------------------------------------------------------------------------
package scint_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int RAD_WIDTH      = COORD_WIDTH - 1;
    localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
    localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH      = PROD_WIDTH + 1;
    localparam int MAG_WIDTH      = SUM_WIDTH + 1;
    localparam int HALF_WIDTH     = MAG_WIDTH / 2;
    localparam int SQ_WIDTH       = 2 * MAG_WIDTH;
    localparam int DISC_WIDTH     = SQ_WIDTH + 1;
    localparam int T_FRAC         = 16;
    localparam int RADICAND_WIDTH = SQ_WIDTH + 2 * T_FRAC;
    localparam int ROOT_WIDTH     = RADICAND_WIDTH / 2;
    localparam int REM_WIDTH      = ROOT_WIDTH + 2;
    localparam int NUM_WIDTH      = ROOT_WIDTH + 2;
    localparam int NMAG_WIDTH     = ROOT_WIDTH + 1;
    localparam int QUOT_WIDTH     = 32;
    localparam int DCMP_WIDTH     = SUM_WIDTH + QUOT_WIDTH;

    localparam logic signed [QUOT_WIDTH-1:0] T_ONE = 32'sh0001_0000;
    localparam logic signed [QUOT_WIDTH-1:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QUOT_WIDTH-1:0] T_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [NUM_WIDTH-1:0]   t_num;

    typedef struct packed {
        logic ok;       // nonzero length and discriminant not negative
        logic tangent;  // discriminant exactly zero
    } t_cls;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] dot;
        logic [SUM_WIDTH-1:0]        len2;
        t_cls                        cls;
    } t_side;

    typedef struct packed {
        t_cls cls;
        logic neg0;
        logic neg1;
        logic big0;
        logic big1;
    } t_dflag;

    typedef struct packed {
        logic                         hit;
        logic [1:0]                   hit_count;
        logic signed [QUOT_WIDTH-1:0] param_near;
        logic signed [QUOT_WIDTH-1:0] param_far;
    } t_result;

endpackage

// ----- hw/rtl/scint_disc.sv -----
// ----------------------------------------------------------------------------
// scint_disc
// Seven-stage front end: offsets, products, dot / len2 / p2-r2, magnitudes,
// split wide products and the signed discriminant.
// ----------------------------------------------------------------------------
module scint_disc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  scint_pkg::t_coord                 i_seg_start_x,
    input  scint_pkg::t_coord                 i_seg_start_y,
    input  scint_pkg::t_coord                 i_seg_end_x,
    input  scint_pkg::t_coord                 i_seg_end_y,
    input  scint_pkg::t_coord                 i_center_x,
    input  scint_pkg::t_coord                 i_center_y,
    input  logic [scint_pkg::RAD_WIDTH-1:0]   i_circle_radius,
    output logic                              o_valid,
    output logic [scint_pkg::SQ_WIDTH-1:0]    o_rad,
    output scint_pkg::t_side                  o_side
);

    localparam int RW   = scint_pkg::RAD_WIDTH;
    localparam int PW   = scint_pkg::PROD_WIDTH;
    localparam int SW   = scint_pkg::SUM_WIDTH;
    localparam int MW   = scint_pkg::MAG_WIDTH;
    localparam int HW   = scint_pkg::HALF_WIDTH;
    localparam int SQ   = scint_pkg::SQ_WIDTH;
    localparam int DW   = scint_pkg::DISC_WIDTH;

    logic [7:1] r_v;

    // stage 1
    scint_pkg::t_diff r1_ax, r1_ay, r1_vx, r1_vy;
    logic [RW-1:0]    r1_r;
    // stage 2
    logic signed [PW-1:0] r2_axvx, r2_ayvy, r2_vxvx, r2_vyvy, r2_axax, r2_ayay;
    logic [2*RW-1:0]      r2_rr;
    // stage 3
    logic signed [SW-1:0] r3_dot;
    logic [SW-1:0]        r3_len2;
    logic signed [MW-1:0] r3_e;
    // stage 4
    logic [MW-1:0]        r4_dotm, r4_len2m, r4_em;
    logic signed [SW-1:0] r4_dot;
    logic [SW-1:0]        r4_len2;
    logic                 r4_eneg, r4_lnz;
    // stage 5
    logic [2*HW-1:0]      r5_dd_ll, r5_dd_lh, r5_dd_hh;
    logic [2*HW-1:0]      r5_le_ll, r5_le_lh, r5_le_hl, r5_le_hh;
    logic signed [SW-1:0] r5_dot;
    logic [SW-1:0]        r5_len2;
    logic                 r5_eneg, r5_lnz;
    // stage 6
    logic [SQ-1:0]        r6_dd, r6_le;
    logic signed [SW-1:0] r6_dot;
    logic [SW-1:0]        r6_len2;
    logic                 r6_eneg, r6_lnz;
    // stage 7
    logic [SQ-1:0]        r7_rad;
    scint_pkg::t_side     r7_side;

    logic signed [MW-1:0] n4_dot_ext;
    logic [DW-1:0]        n7_disc;
    logic                 n7_neg;

    assign n4_dot_ext = MW'(r3_dot);
    assign n7_disc    = r6_eneg ? (DW'(r6_dd) + DW'(r6_le)) : (DW'(r6_dd) - DW'(r6_le));
    assign n7_neg     = n7_disc[DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax <= scint_pkg::t_diff'(i_seg_start_x) - scint_pkg::t_diff'(i_center_x);
            r1_ay <= scint_pkg::t_diff'(i_seg_start_y) - scint_pkg::t_diff'(i_center_y);
            r1_vx <= scint_pkg::t_diff'(i_seg_end_x) - scint_pkg::t_diff'(i_seg_start_x);
            r1_vy <= scint_pkg::t_diff'(i_seg_end_y) - scint_pkg::t_diff'(i_seg_start_y);
            r1_r  <= i_circle_radius;

            r2_axvx <= r1_ax * r1_vx;
            r2_ayvy <= r1_ay * r1_vy;
            r2_vxvx <= r1_vx * r1_vx;
            r2_vyvy <= r1_vy * r1_vy;
            r2_axax <= r1_ax * r1_ax;
            r2_ayay <= r1_ay * r1_ay;
            r2_rr   <= r1_r * r1_r;

            r3_dot  <= SW'(r2_axvx) + SW'(r2_ayvy);
            r3_len2 <= SW'($unsigned(r2_vxvx)) + SW'($unsigned(r2_vyvy));
            r3_e    <= MW'(r2_axax) + MW'(r2_ayay) - $signed(MW'(r2_rr));

            r4_dotm  <= n4_dot_ext[MW-1] ? $unsigned(-n4_dot_ext) : $unsigned(n4_dot_ext);
            r4_em    <= r3_e[MW-1] ? $unsigned(-r3_e) : $unsigned(r3_e);
            r4_len2m <= MW'(r3_len2);
            r4_dot   <= r3_dot;
            r4_len2  <= r3_len2;
            r4_eneg  <= r3_e[MW-1];
            r4_lnz   <= |r3_len2;

            // 52-bit partial products of the 26-bit halves for dot^2 and len2*|e|
            r5_dd_ll <= r4_dotm[HW-1:0]  * r4_dotm[HW-1:0];
            r5_dd_lh <= r4_dotm[HW-1:0]  * r4_dotm[MW-1:HW];
            r5_dd_hh <= r4_dotm[MW-1:HW] * r4_dotm[MW-1:HW];
            r5_le_ll <= r4_len2m[HW-1:0]  * r4_em[HW-1:0];
            r5_le_lh <= r4_len2m[HW-1:0]  * r4_em[MW-1:HW];
            r5_le_hl <= r4_len2m[MW-1:HW] * r4_em[HW-1:0];
            r5_le_hh <= r4_len2m[MW-1:HW] * r4_em[MW-1:HW];
            r5_dot   <= r4_dot;
            r5_len2  <= r4_len2;
            r5_eneg  <= r4_eneg;
            r5_lnz   <= r4_lnz;

            r6_dd <= (SQ'(r5_dd_hh) << (2 * HW)) + (SQ'(r5_dd_lh) << (HW + 1))
                   + SQ'(r5_dd_ll);
            r6_le <= (SQ'(r5_le_hh) << (2 * HW))
                   + ((SQ'(r5_le_lh) + SQ'(r5_le_hl)) << HW) + SQ'(r5_le_ll);
            r6_dot  <= r5_dot;
            r6_len2 <= r5_len2;
            r6_eneg <= r5_eneg;
            r6_lnz  <= r5_lnz;

            r7_rad              <= n7_neg ? '0 : n7_disc[SQ-1:0];
            r7_side.dot         <= r6_dot;
            r7_side.len2        <= r6_len2;
            r7_side.cls.ok      <= r6_lnz && !n7_neg;
            r7_side.cls.tangent <= (n7_disc == '0);
        end
    end

    assign o_valid = r_v[7];
    assign o_rad   = r7_rad;
    assign o_side  = r7_side;

endmodule

// ----- hw/rtl/scint_sqrt.sv -----
// ----------------------------------------------------------------------------
// scint_sqrt
// Pipelined digit-recurrence integer square root of the discriminant
// scaled by 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module scint_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [scint_pkg::SQ_WIDTH-1:0]   i_rad,
    input  scint_pkg::t_side                 i_side,
    output logic                             o_valid,
    output logic [scint_pkg::ROOT_WIDTH-1:0] o_root,
    output scint_pkg::t_side                 o_side
);

    localparam int STEPS = scint_pkg::ROOT_WIDTH;
    localparam int RMW   = scint_pkg::REM_WIDTH;
    localparam int XW    = scint_pkg::RADICAND_WIDTH;

    logic             a_v    [STEPS];
    logic [RMW-1:0]   a_rem  [STEPS];
    logic [STEPS-1:0] a_root [STEPS];
    logic [XW-1:0]    a_x    [STEPS];
    scint_pkg::t_side a_side [STEPS];

    logic             r_v    [STEPS];
    logic [RMW-1:0]   r_rem  [STEPS];
    logic [STEPS-1:0] r_root [STEPS];
    logic [XW-1:0]    r_x    [STEPS];
    scint_pkg::t_side r_side [STEPS];

    assign a_v[0]    = i_valid;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_x[0]    = {i_rad, (2 * scint_pkg::T_FRAC)'(0)};
    assign a_side[0] = i_side;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_stage
            logic [RMW-1:0] n_sh;
            logic [RMW-1:0] n_trial;
            logic           n_ge;

            if (k > 0) begin : g_link
                assign a_v[k]    = r_v[k-1];
                assign a_rem[k]  = r_rem[k-1];
                assign a_root[k] = r_root[k-1];
                assign a_x[k]    = r_x[k-1];
                assign a_side[k] = r_side[k-1];
            end

            // bring down the next two radicand bits and try root*4+1
            assign n_sh    = {a_rem[k][RMW-3:0], a_x[k][XW-1 -: 2]};
            assign n_trial = {a_root[k], 2'b01};
            assign n_ge    = (n_sh >= n_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= a_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_ge ? (n_sh - n_trial) : n_sh;
                    r_root[k] <= {a_root[k][STEPS-2:0], n_ge};
                    r_x[k]    <= {a_x[k][XW-3:0], 2'b00};
                    r_side[k] <= a_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

// ----- hw/rtl/scint_div.sv -----
// ----------------------------------------------------------------------------
// scint_div
// Two-lane pipelined restoring divider: both signed numerators over len2,
// with overflow detection, one quotient bit per stage.
// ----------------------------------------------------------------------------
module scint_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  scint_pkg::t_num                  i_num0,
    input  scint_pkg::t_num                  i_num1,
    input  logic [scint_pkg::SUM_WIDTH-1:0]  i_len2,
    input  scint_pkg::t_cls                  i_cls,
    output logic                             o_valid,
    output logic [scint_pkg::QUOT_WIDTH-1:0] o_quot0,
    output logic [scint_pkg::QUOT_WIDTH-1:0] o_quot1,
    output scint_pkg::t_dflag                o_flag
);

    localparam int NMW = scint_pkg::NMAG_WIDTH;
    localparam int SW  = scint_pkg::SUM_WIDTH;
    localparam int QW  = scint_pkg::QUOT_WIDTH;
    localparam int CW  = scint_pkg::DCMP_WIDTH;

    // magnitude stage
    logic              r_m_v;
    logic [NMW-1:0]    r_m_mag0, r_m_mag1;
    logic [SW-1:0]     r_m_len2;
    scint_pkg::t_dflag r_m_flag;
    // overflow stage
    logic              r_b_v;
    logic [CW-1:0]     r_b_rem0, r_b_rem1;
    logic [SW-1:0]     r_b_len2;
    scint_pkg::t_dflag r_b_flag;

    logic [CW-1:0]     n_b_lim;

    assign n_b_lim = CW'(r_m_len2) << QW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= i_valid;
            r_b_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_mag0      <= NMW'(i_num0[scint_pkg::NUM_WIDTH-1] ? -i_num0 : i_num0);
            r_m_mag1      <= NMW'(i_num1[scint_pkg::NUM_WIDTH-1] ? -i_num1 : i_num1);
            r_m_len2      <= i_len2;
            r_m_flag.cls  <= i_cls;
            r_m_flag.neg0 <= i_num0[scint_pkg::NUM_WIDTH-1];
            r_m_flag.neg1 <= i_num1[scint_pkg::NUM_WIDTH-1];
            r_m_flag.big0 <= 1'b0;
            r_m_flag.big1 <= 1'b0;

            r_b_rem0      <= CW'(r_m_mag0);
            r_b_rem1      <= CW'(r_m_mag1);
            r_b_len2      <= r_m_len2;
            r_b_flag.cls  <= r_m_flag.cls;
            r_b_flag.neg0 <= r_m_flag.neg0;
            r_b_flag.neg1 <= r_m_flag.neg1;
            r_b_flag.big0 <= (CW'(r_m_mag0) >= n_b_lim);
            r_b_flag.big1 <= (CW'(r_m_mag1) >= n_b_lim);
        end
    end

    logic              a_v    [QW];
    logic [CW-1:0]     a_rem0 [QW];
    logic [CW-1:0]     a_rem1 [QW];
    logic [QW-1:0]     a_q0   [QW];
    logic [QW-1:0]     a_q1   [QW];
    logic [SW-1:0]     a_len2 [QW];
    scint_pkg::t_dflag a_flag [QW];

    logic              r_v    [QW];
    logic [CW-1:0]     r_rem0 [QW];
    logic [CW-1:0]     r_rem1 [QW];
    logic [QW-1:0]     r_q0   [QW];
    logic [QW-1:0]     r_q1   [QW];
    logic [SW-1:0]     r_len2 [QW];
    scint_pkg::t_dflag r_flag [QW];

    assign a_v[0]    = r_b_v;
    assign a_rem0[0] = r_b_rem0;
    assign a_rem1[0] = r_b_rem1;
    assign a_q0[0]   = '0;
    assign a_q1[0]   = '0;
    assign a_len2[0] = r_b_len2;
    assign a_flag[0] = r_b_flag;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int BIT = QW - 1 - k;
            logic [CW-1:0] n_sh;
            logic          n_ge0, n_ge1;

            if (k > 0) begin : g_link
                assign a_v[k]    = r_v[k-1];
                assign a_rem0[k] = r_rem0[k-1];
                assign a_rem1[k] = r_rem1[k-1];
                assign a_q0[k]   = r_q0[k-1];
                assign a_q1[k]   = r_q1[k-1];
                assign a_len2[k] = r_len2[k-1];
                assign a_flag[k] = r_flag[k-1];
            end

            assign n_sh  = CW'(a_len2[k]) << BIT;
            assign n_ge0 = (a_rem0[k] >= n_sh);
            assign n_ge1 = (a_rem1[k] >= n_sh);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= a_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem0[k] <= n_ge0 ? (a_rem0[k] - n_sh) : a_rem0[k];
                    r_rem1[k] <= n_ge1 ? (a_rem1[k] - n_sh) : a_rem1[k];
                    r_q0[k]   <= a_q0[k] | (QW'(n_ge0) << BIT);
                    r_q1[k]   <= a_q1[k] | (QW'(n_ge1) << BIT);
                    r_len2[k] <= a_len2[k];
                    r_flag[k] <= a_flag[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_quot0 = r_q0[QW-1];
    assign o_quot1 = r_q1[QW-1];
    assign o_flag  = r_flag[QW-1];

endmodule

// ----- hw/rtl/segment_circle_intersect.sv -----
// ----------------------------------------------------------------------------
// segment_circle_intersect
// Segment against circle hit test with Q15.16 line parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with the segment endpoints, circle
//   center (signed Q12.12) and radius (unsigned Q11.12). A transaction
//   happens on a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with hit, hit_count and the two
//   saturated Q15.16 parameters; a transaction happens with o_valid high and
//   i_stall low.
//   From input transaction to o_valid a query passes through 7 front-end
//   stages, 68 square-root stages (one root bit each), 1 numerator stage,
//   34 divider stages (magnitude, overflow check, 32 quotient bits) and the
//   output register. One transaction per cycle while o_stall is low.
//   The output register has a one-entry skid buffer behind it, so a result
//   waiting on i_stall does not block the next input; once the skid entry is
//   also full, o_stall rises and the whole pipeline holds.
//   Synchronous active-low reset clears all valid bits, including the output
//   and skid valid flags; no results are pending afterward.
module segment_circle_intersect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  scint_pkg::t_coord               i_seg_start_x,
    input  scint_pkg::t_coord               i_seg_start_y,
    input  scint_pkg::t_coord               i_seg_end_x,
    input  scint_pkg::t_coord               i_seg_end_y,
    input  scint_pkg::t_coord               i_center_x,
    input  scint_pkg::t_coord               i_center_y,
    input  logic [scint_pkg::RAD_WIDTH-1:0] i_circle_radius,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic [1:0]                      o_hit_count,
    output logic signed [31:0]              o_param_near,
    output logic signed [31:0]              o_param_far
);

    localparam int QW = scint_pkg::QUOT_WIDTH;

    logic                             en;
    logic                             out_take;

    logic                             c_v;
    logic [scint_pkg::SQ_WIDTH-1:0]   c_rad;
    scint_pkg::t_side                 c_side;

    logic                             s_v;
    logic [scint_pkg::ROOT_WIDTH-1:0] s_root;
    scint_pkg::t_side                 s_side;

    logic                             r_num_v;
    scint_pkg::t_num                  r_num0, r_num1;
    logic [scint_pkg::SUM_WIDTH-1:0]  r_num_len2;
    scint_pkg::t_cls                  r_num_cls;
    scint_pkg::t_num                  n_nd, n_s;

    logic                             d_v;
    logic [QW-1:0]                    d_q0, d_q1;
    scint_pkg::t_dflag                d_flag;

    logic signed [QW-1:0]             n_t0, n_t1;
    logic                             n_in0, n_in1;
    logic [1:0]                       n_cnt;
    scint_pkg::t_result               n_res;

    logic                             r_out_v, r_skid_v;
    scint_pkg::t_result               r_out, r_skid;

    function automatic logic signed [31:0] sat_quot(input logic [31:0] q,
                                                    input logic neg,
                                                    input logic big);
        logic signed [31:0] res;
        if (!neg) begin
            res = (big || q[31]) ? scint_pkg::T_MAX : $signed(q);
        end else begin
            res = (big || (q[31] && (|q[30:0]))) ? scint_pkg::T_MIN : -$signed(q);
        end
        return res;
    endfunction

    function automatic logic in_unit(input logic signed [31:0] t);
        return !t[31] && (t <= scint_pkg::T_ONE);
    endfunction

    assign en       = !r_skid_v;
    assign o_stall  = r_skid_v;
    assign out_take = r_out_v && !i_stall;

    scint_disc u_disc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_seg_start_x   (i_seg_start_x),
        .i_seg_start_y   (i_seg_start_y),
        .i_seg_end_x     (i_seg_end_x),
        .i_seg_end_y     (i_seg_end_y),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .o_valid         (c_v),
        .o_rad           (c_rad),
        .o_side          (c_side)
    );

    scint_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_v),
        .i_rad   (c_rad),
        .i_side  (c_side),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // numerators -dot*2^16 -/+ sqrt
    assign n_nd = -(scint_pkg::t_num'(s_side.dot) <<< scint_pkg::T_FRAC);
    assign n_s  = $signed({2'b00, s_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_v <= 1'b0;
        end else if (en) begin
            r_num_v <= s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num0     <= n_nd - n_s;
            r_num1     <= n_nd + n_s;
            r_num_len2 <= s_side.len2;
            r_num_cls  <= s_side.cls;
        end
    end

    scint_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_num_v),
        .i_num0  (r_num0),
        .i_num1  (r_num1),
        .i_len2  (r_num_len2),
        .i_cls   (r_num_cls),
        .o_valid (d_v),
        .o_quot0 (d_q0),
        .o_quot1 (d_q1),
        .o_flag  (d_flag)
    );

    always_comb begin
        n_t0  = sat_quot(d_q0, d_flag.neg0, d_flag.big0);
        n_t1  = sat_quot(d_q1, d_flag.neg1, d_flag.big1);
        n_in0 = in_unit(n_t0);
        n_in1 = in_unit(n_t1);
        if (!d_flag.cls.ok) begin
            n_cnt = 2'd0;
        end else if (d_flag.cls.tangent) begin
            n_cnt = {1'b0, n_in0};
        end else begin
            n_cnt = {1'b0, n_in0} + {1'b0, n_in1};
        end
        n_res.hit        = (n_cnt != 2'd0);
        n_res.hit_count  = n_cnt;
        n_res.param_near = (n_cnt == 2'd0) ? '0 : n_t0;
        n_res.param_far  = (n_cnt == 2'd0) ? '0 : n_t1;
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (d_v) begin
            if (r_out_v && !out_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (d_v) begin
            if (r_out_v && !out_take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_hit        = r_out.hit;
    assign o_hit_count  = r_out.hit_count;
    assign o_param_near = r_out.param_near;
    assign o_param_far  = r_out.param_far;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid entry filled while output was free");

    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_hit == (o_hit_count != 2'd0)) && (o_hit_count != 2'd3)))
        else $error("hit flag and count disagree");

    a_zero_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_param_near == '0) && (o_param_far == '0)))
        else $error("parameters nonzero without a hit");

    a_param_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hit_count == 2'd2)) |-> (o_param_near <= o_param_far))
        else $error("near parameter above far parameter");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_circle_intersect.
//
// Directed segment / circle cases, followed by random queries. Most random
// queries are built around the circle, so hits, misses and tangents all come
// up. Each accepted query is predicted in exact wide integer arithmetic. Each
// result is compared field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_RANDOM     = 1600;
    localparam int DRAIN_CYCLES   = 150;

    typedef logic signed [159:0] t_big;
    typedef logic [scint_pkg::RAD_WIDTH-1:0] t_rad;

    typedef struct {
        scint_pkg::t_coord sx, sy, ex, ey, cx, cy;
        t_rad              rad;
    } t_query;

    class hit_scoreboard;
        scint_pkg::t_result pending[$];
        int                 errors;
        int                 checked;
        int                 count_seen[3];

        function void note_query(scint_pkg::t_result r);
            pending.push_back(r);
        endfunction

        function void check_result(scint_pkg::t_result got);
            scint_pkg::t_result want;
            if (pending.size() == 0) begin
                $error("result with no query outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.hit_count <= 2) count_seen[got.hit_count]++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.hit_count !== want.hit_count) begin
                $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
                errors++;
            end
            if (got.param_near !== want.param_near) begin
                $error("param_near: expected %0d, got %0d", want.param_near, got.param_near);
                errors++;
            end
            if (got.param_far !== want.param_far) begin
                $error("param_far: expected %0d, got %0d", want.param_far, got.param_far);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    scint_pkg::t_coord  i_seg_start_x, i_seg_start_y, i_seg_end_x, i_seg_end_y;
    scint_pkg::t_coord  i_center_x, i_center_y;
    t_rad               i_circle_radius;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    logic [1:0]         o_hit_count;
    logic signed [31:0] o_param_near;
    logic signed [31:0] o_param_far;

    hit_scoreboard sb;
    int            idle_cycles = 0;
    int            tangent_queries;
    bit            steady_out;

    segment_circle_intersect dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_big clamp_q16(t_big q);
        if (q > scint_pkg::T_MAX) return scint_pkg::T_MAX;
        if (q < scint_pkg::T_MIN) return scint_pkg::T_MIN;
        return q;
    endfunction

    function automatic bit on_segment(t_big t);
        return t >= 0 && t <= scint_pkg::T_ONE;
    endfunction

    // exact line parameters, floor square root and truncating divide
    function automatic scint_pkg::t_result predict_hits(t_query q);
        t_big               ax, ay, vx, vy, dot, len2, p2, r2, disc, rad_q, nd, root, cand;
        t_big               t0, t1;
        scint_pkg::t_result res;
        int                 cnt;
        rad_q = q.rad;
        ax    = t_big'(q.sx) - t_big'(q.cx);
        ay    = t_big'(q.sy) - t_big'(q.cy);
        vx    = t_big'(q.ex) - t_big'(q.sx);
        vy    = t_big'(q.ey) - t_big'(q.sy);
        dot   = ax * vx + ay * vy;
        len2  = vx * vx + vy * vy;
        p2    = ax * ax + ay * ay;
        r2    = rad_q * rad_q;
        disc  = dot * dot - len2 * (p2 - r2);
        cnt   = 0;
        t0    = 0;
        t1    = 0;
        if (len2 != 0 && disc >= 0) begin
            nd   = -(dot <<< scint_pkg::T_FRAC);
            root = 0;
            for (int b = 71; b >= 0; b--) begin
                cand = root | (t_big'(1) << b);
                if (cand * cand <= (disc <<< 2 * scint_pkg::T_FRAC)) root = cand;
            end
            t0 = clamp_q16((nd - root) / len2);
            t1 = clamp_q16((nd + root) / len2);
            if (disc == 0) cnt = on_segment(t0);
            else cnt = on_segment(t0) + on_segment(t1);
        end
        if (cnt == 0) begin
            t0 = 0;
            t1 = 0;
        end
        res.hit        = cnt > 0;
        res.hit_count  = cnt[1:0];
        res.param_near = t0[31:0];
        res.param_far  = t1[31:0];
        return res;
    endfunction

    // monitor both channels and run the watchdog
    always @(posedge i_clk) begin
        t_query             q;
        scint_pkg::t_result got;
        bit                 busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_valid && !o_stall) begin
                q.sx = i_seg_start_x;
                q.sy = i_seg_start_y;
                q.ex = i_seg_end_x;
                q.ey = i_seg_end_y;
                q.cx = i_center_x;
                q.cy = i_center_y;
                q.rad = i_circle_radius;
                sb.note_query(predict_hits(q));
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                got.hit        = o_hit;
                got.hit_count  = o_hit_count;
                got.param_near = o_param_near;
                got.param_far  = o_param_far;
                sb.check_result(got);
                busy = 1'b1;
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("** segment_circle_intersect: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stall before each result, with stall-free stretches
    initial begin
        int n;
        i_stall <= 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = steady_out ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk iff o_valid);
        end
    end

    task automatic send_query(t_query q, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_seg_start_x   <= q.sx;
        i_seg_start_y   <= q.sy;
        i_seg_end_x     <= q.ex;
        i_seg_end_y     <= q.ey;
        i_center_x      <= q.cx;
        i_center_y      <= q.cy;
        i_circle_radius <= q.rad;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic t_query make_query(int sx, int sy, int ex, int ey,
                                          int cx, int cy, int rad);
        t_query q;
        q.sx = sx[scint_pkg::COORD_WIDTH-1:0];
        q.sy = sy[scint_pkg::COORD_WIDTH-1:0];
        q.ex = ex[scint_pkg::COORD_WIDTH-1:0];
        q.ey = ey[scint_pkg::COORD_WIDTH-1:0];
        q.cx = cx[scint_pkg::COORD_WIDTH-1:0];
        q.cy = cy[scint_pkg::COORD_WIDTH-1:0];
        q.rad = rad[scint_pkg::RAD_WIDTH-1:0];
        return q;
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // most queries are placed around the circle, the rest are raw bits
    function automatic t_query random_query();
        int     scale, r, cx, cy, kind;
        t_query q;
        kind  = $urandom_range(0, 9);
        scale = $urandom_range(2, 20);
        r     = $urandom_range(0, 1 << scale);
        cx    = rand_span(1 << 22);
        cy    = rand_span(1 << 22);
        if (kind == 0) begin
            q.sx = scint_pkg::t_coord'($urandom);
            q.sy = scint_pkg::t_coord'($urandom);
            q.ex = scint_pkg::t_coord'($urandom);
            q.ey = scint_pkg::t_coord'($urandom);
            q.cx = scint_pkg::t_coord'($urandom);
            q.cy = scint_pkg::t_coord'($urandom);
            q.rad = t_rad'($urandom);
        end else if (kind == 1) begin
            // horizontal segment on the line tangent to the top of the circle
            q = make_query(cx - rand_span(2 * r), cy + r, cx + rand_span(2 * r), cy + r,
                           cx, cy, r);
        end else if (kind == 2) begin
            // degenerate: both endpoints equal
            q = make_query(cx + rand_span(r), cy, cx + rand_span(r), cy, cx, cy, r);
            q.ex = q.sx;
            q.ey = q.sy;
        end else begin
            q = make_query(cx + rand_span(2 * r + 4), cy + rand_span(2 * r + 4),
                           cx + rand_span(2 * r + 4), cy + rand_span(2 * r + 4), cx, cy, r);
        end
        return q;
    endfunction

    initial begin
        t_query directed[$];
        t_query q;
        int     gap;
        sb = new();
        tangent_queries = 0;
        steady_out      = 0;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_seg_start_x   <= '0;
        i_seg_start_y   <= '0;
        i_seg_end_x     <= '0;
        i_seg_end_y     <= '0;
        i_center_x      <= '0;
        i_center_y      <= '0;
        i_circle_radius <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two crossings, miss, tangent, zero length, endpoints on circle
        directed.push_back(make_query(-8192, 0, 8192, 0, 0, 0, 4096));
        directed.push_back(make_query(-8192, 8192, 8192, 8192, 0, 0, 4096));
        directed.push_back(make_query(-8192, 4096, 8192, 4096, 0, 0, 4096));
        directed.push_back(make_query(0, 4096, 8192, 4096, 0, 0, 4096));
        directed.push_back(make_query(100, 200, 100, 200, 100, 200, 50));
        directed.push_back(make_query(-4096, 0, 4096, 0, 0, 0, 4096));
        directed.push_back(make_query(0, 0, 100, 0, 0, 0, 4096));
        directed.push_back(make_query(-100, 0, 100, 0, 0, 0, 0));
        directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
        // tiny step far from a large circle saturates both parameters
        directed.push_back(make_query(-8388608, 0, -8388607, 0, 8388607, 0, 8388607));
        directed.push_back(make_query(8388607, 8388607, -8388608, -8388608,
                                      0, 0, 8388607));
        directed.push_back(make_query(-8388608, -8388608, 8388607, 8388607,
                                      8388607, -8388608, 8388607));
        directed.push_back(make_query(8388607, -8388608, -8388608, 8388607,
                                      -8388608, 8388607, 0));
        directed.push_back(make_query(-8388608, 0, 8388607, 0, 0, 0, 8388607));
        directed.push_back(make_query(0, -8388608, 0, 8388607, 0, 0, 1));
        directed.push_back(make_query(3, 7, 3, 7, -8388608, -8388608, 8388607));
        foreach (directed[k]) send_query(directed[k], $urandom_range(0, 3));

        for (int k = 0; k < NUM_RANDOM; k++) begin
            steady_out = (k / 200) % 3 == 1;
            gap = ((k / 150) % 4 == 2) ? 0 : $urandom_range(0, 14);
            q = random_query();
            if (q.sy == q.ey && q.sy == q.cy + scint_pkg::t_coord'(q.rad)) tangent_queries++;
            send_query(q, gap);
        end
        i_valid    <= 1'b0;
        steady_out = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d results: %0d with no hit, %0d single hits, %0d double hits",
                 sb.checked, sb.count_seen[0], sb.count_seen[1], sb.count_seen[2]);
        $display("%0d random queries aimed at a tangent line", tangent_queries);
        if (sb.errors == 0) begin
            $display("** segment_circle_intersect: PASSED **");
        end else begin
            $display("** segment_circle_intersect: FAILED **");
        end
        $finish;
    end

endmodule

// ----- segment_circle_intersect.f -----
hw/rtl/scint_pkg.sv
hw/rtl/scint_disc.sv
hw/rtl/scint_sqrt.sv
hw/rtl/scint_div.sv
hw/rtl/segment_circle_intersect.sv
test/tb.sv
